// ===== hw/rtl/cylinder_vertex_generator_macros.svh =====
// Assertion macros for the cylinder vertex generator.
// Taken in by the top level only; no other dependency.
`ifndef CYLINDER_VERTEX_GENERATOR_MACROS_SVH
`define CYLINDER_VERTEX_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CVG_ASSERT_IMPL(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("cylinder_vertex_generator: check failed");
`define CVG_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("cylinder_vertex_generator: check failed");
`else
`define CVG_ASSERT_IMPL(name, clk, rst, pre, post)
`define CVG_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

// ===== hw/rtl/cvg_pkg.sv =====
// Shared types, constants and step functions of the cylinder vertex generator.
// Used by cvg_divider, cvg_cordic and the top level; depends on nothing.
`timescale 1ns / 1ps

package cvg_pkg;

  localparam int SEG_W        = 11;
  localparam int N_MIN        = 6;
  localparam int N_MAX        = 1024;
  localparam int ANGLE_BITS   = 16;
  localparam int TEX_SHIFT    = 15;
  localparam int DIV_STEPS    = ANGLE_BITS + 1;
  localparam int DIVIDEND_W   = SEG_W + ANGLE_BITS;
  localparam int TURN_W       = 32;
  localparam int CORDIC_STEPS = 20;
  localparam int XY_W         = 33;
  localparam int Z_W          = 32;
  localparam int CS_W         = 32;
  localparam int RAD_W        = 15;
  localparam int LEN_W        = 15;
  localparam int PROD_W       = 48;
  localparam int POS_W        = 16;
  localparam int NORM_W       = 16;
  localparam int TEX_W        = 16;
  localparam int SLOT_W       = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 15;

  localparam logic signed [XY_W-1:0] CORDIC_X0  = XY_W'(64'h26DD3B6A);
  localparam logic signed [CS_W-1:0] ONE_Q30    = CS_W'(64'h40000000);
  localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(16384);
  localparam logic [TEX_W-1:0] TEX_ONE          = TEX_W'(32768);

  typedef logic [SEG_W-1:0] seg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS   = 2'd0,
    REG_LENGTH   = 2'd1,
    REG_SEGMENTS = 2'd2,
    REG_CAPS     = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_SIDE_BOTTOM = 2'd0,
    KIND_SIDE_TOP    = 2'd1,
    KIND_CAP_BOTTOM  = 2'd2,
    KIND_CAP_TOP     = 2'd3
  } vertex_kind_t;

  typedef struct packed {
    seg_t                 idx;
    seg_t                 rem_p;
    seg_t                 rem_u;
    logic [DIV_STEPS-1:0] low_p;
    logic [DIV_STEPS-1:0] low_u;
    logic [DIV_STEPS-1:0] q_p;
    logic [DIV_STEPS-1:0] q_u;
  } div_item_t;

  typedef struct packed {
    seg_t                   idx;
    logic [TEX_W-1:0]       tex_u;
    logic [1:0]             quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_item_t;

  function automatic div_item_t div_step(input div_item_t a, input seg_t n);
    logic [SEG_W:0] tp;
    logic [SEG_W:0] tu;
    div_item_t r;
    r = a;
    tp = {a.rem_p, a.low_p[DIV_STEPS-1]};
    tu = {a.rem_u, a.low_u[DIV_STEPS-1]};
    r.low_p = a.low_p << 1;
    r.low_u = a.low_u << 1;
    if (tp >= {1'b0, n}) begin
      r.rem_p = SEG_W'(tp - {1'b0, n});
      r.q_p   = {a.q_p[DIV_STEPS-2:0], 1'b1};
    end else begin
      r.rem_p = tp[SEG_W-1:0];
      r.q_p   = {a.q_p[DIV_STEPS-2:0], 1'b0};
    end
    if (tu >= {1'b0, n}) begin
      r.rem_u = SEG_W'(tu - {1'b0, n});
      r.q_u   = {a.q_u[DIV_STEPS-2:0], 1'b1};
    end else begin
      r.rem_u = tu[SEG_W-1:0];
      r.q_u   = {a.q_u[DIV_STEPS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [Z_W-1:0] atan_turn(input int unsigned k);
    case (k)
      0:  return Z_W'(536870912);
      1:  return Z_W'(316933406);
      2:  return Z_W'(167458907);
      3:  return Z_W'(85004756);
      4:  return Z_W'(42667331);
      5:  return Z_W'(21354465);
      6:  return Z_W'(10680862);
      7:  return Z_W'(5340245);
      8:  return Z_W'(2670675);
      9:  return Z_W'(1335087);
      10: return Z_W'(667544);
      11: return Z_W'(333772);
      12: return Z_W'(166886);
      13: return Z_W'(83443);
      14: return Z_W'(41722);
      15: return Z_W'(20861);
      16: return Z_W'(10430);
      17: return Z_W'(5215);
      18: return Z_W'(2608);
      19: return Z_W'(1304);
      default: return '0;
    endcase
  endfunction

  function automatic rot_item_t rot_step(input rot_item_t a, input int unsigned k);
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    rot_item_t r;
    r = a;
    dx = $signed(a.y) >>> k;
    dy = $signed(a.x) >>> k;
    if (!a.z[Z_W-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_turn(k);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_turn(k);
    end
    return r;
  endfunction

  function automatic logic signed [CS_W-1:0] sat_unit(input logic signed [XY_W-1:0] v);
    if (v > XY_W'(ONE_Q30)) begin
      return ONE_Q30;
    end else if (v < -XY_W'(ONE_Q30)) begin
      return -ONE_Q30;
    end
    return CS_W'(v);
  endfunction

  function automatic logic signed [NORM_W-1:0] norm_of(input logic signed [CS_W-1:0] v);
    logic signed [CS_W:0] t;
    t = ($signed({v[CS_W-1], v}) + (CS_W+1)'(32768)) >>> 16;
    if (t > (CS_W+1)'(16384)) begin
      return NORM_ONE;
    end else if (t < -(CS_W+1)'(16384)) begin
      return -NORM_ONE;
    end
    return NORM_W'(t);
  endfunction

  function automatic logic signed [POS_W-1:0] pos_of(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + (PROD_W'(1) <<< 29)) >>> 30;
    if (t > PROD_W'(32767)) begin
      return POS_W'(32767);
    end else if (t < -PROD_W'(32768)) begin
      return POS_W'(-32768);
    end
    return POS_W'(t);
  endfunction

endpackage

// ===== hw/rtl/cvg_divider.sv =====
// Pipelined restoring divider: phase and texture u of a ring index over the
// segment count, one quotient bit per stage. Depends on cvg_pkg.
`timescale 1ns / 1ps

module cvg_divider (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                item_valid,
  input  cvg_pkg::seg_t       item_idx,
  input  cvg_pkg::seg_t       n,
  output logic                result_valid,
  output cvg_pkg::div_item_t  result
);

  cvg_pkg::div_item_t                    stage [cvg_pkg::DIV_STEPS];
  logic [cvg_pkg::DIV_STEPS-1:0]         vld;
  cvg_pkg::div_item_t                    init;
  logic [cvg_pkg::DIVIDEND_W-1:0]        dp;
  logic [cvg_pkg::DIVIDEND_W-1:0]        du;

  always_comb begin
    dp = (cvg_pkg::DIVIDEND_W'(item_idx) << cvg_pkg::ANGLE_BITS)
       + cvg_pkg::DIVIDEND_W'(n >> 1);
    du = (cvg_pkg::DIVIDEND_W'(item_idx) << cvg_pkg::TEX_SHIFT)
       + cvg_pkg::DIVIDEND_W'(n >> 1);
    init.idx   = item_idx;
    init.rem_p = cvg_pkg::SEG_W'(dp[cvg_pkg::DIVIDEND_W-1:cvg_pkg::DIV_STEPS]);
    init.rem_u = cvg_pkg::SEG_W'(du[cvg_pkg::DIVIDEND_W-1:cvg_pkg::DIV_STEPS]);
    init.low_p = dp[cvg_pkg::DIV_STEPS-1:0];
    init.low_u = du[cvg_pkg::DIV_STEPS-1:0];
    init.q_p   = '0;
    init.q_u   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[cvg_pkg::DIV_STEPS-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage[0] <= cvg_pkg::div_step(init, n);
      for (int j = 1; j < cvg_pkg::DIV_STEPS; j++) begin
        stage[j] <= cvg_pkg::div_step(stage[j-1], n);
      end
    end
  end

  assign result_valid = vld[cvg_pkg::DIV_STEPS-1];
  assign result       = stage[cvg_pkg::DIV_STEPS-1];

endmodule

// ===== hw/rtl/cvg_cordic.sv =====
// Pipelined CORDIC rotation, one micro-rotation per stage, from the phase
// delivered by cvg_divider. Depends on cvg_pkg.
`timescale 1ns / 1ps

module cvg_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                item_valid,
  input  cvg_pkg::div_item_t  item,
  output logic                result_valid,
  output cvg_pkg::rot_item_t  result
);

  cvg_pkg::rot_item_t               stage [cvg_pkg::CORDIC_STEPS];
  logic [cvg_pkg::CORDIC_STEPS-1:0] vld;
  cvg_pkg::rot_item_t               init;

  always_comb begin
    init.idx   = item.idx;
    init.tex_u = item.q_u[cvg_pkg::TEX_W-1:0];
    init.quad  = item.q_p[cvg_pkg::ANGLE_BITS-1 -: 2];
    init.x     = cvg_pkg::CORDIC_X0;
    init.y     = '0;
    init.z     = cvg_pkg::Z_W'(item.q_p[cvg_pkg::ANGLE_BITS-3:0])
               << (cvg_pkg::TURN_W - cvg_pkg::ANGLE_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[cvg_pkg::CORDIC_STEPS-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage[0] <= cvg_pkg::rot_step(init, 0);
      for (int k = 1; k < cvg_pkg::CORDIC_STEPS; k++) begin
        stage[k] <= cvg_pkg::rot_step(stage[k-1], k);
      end
    end
  end

  assign result_valid = vld[cvg_pkg::CORDIC_STEPS-1];
  assign result       = stage[cvg_pkg::CORDIC_STEPS-1];

endmodule

// ===== hw/rtl/cylinder_vertex_generator.sv =====
// Cylinder vertex generator: for each ring index it delivers the bottom and
// top side vertices and, with caps enabled, the bottom and top cap vertices,
// one vertex transfer per cycle while vertex_stall is low. An index may be
// accepted in every cycle while the pipeline drains; sustained, one index
// takes four vertex transfers with caps and two without, set by the
// single-vertex result port. An index passes 17 divider stages (one quotient
// bit each), 20 CORDIC stages, three scaling stages and the output register.
`timescale 1ns / 1ps

module cylinder_vertex_generator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [cvg_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cvg_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   ring_valid,
  output logic                                   ring_stall,
  input  logic [cvg_pkg::SEG_W-1:0]              ring_index,
  output logic                                   vertex_valid,
  input  logic                                   vertex_stall,
  output logic [cvg_pkg::SLOT_W-1:0]             vertex_slot,
  output logic signed [cvg_pkg::POS_W-1:0]       pos_x,
  output logic signed [cvg_pkg::POS_W-1:0]       pos_y,
  output logic [cvg_pkg::LEN_W-1:0]              pos_z,
  output logic signed [cvg_pkg::NORM_W-1:0]      norm_x,
  output logic signed [cvg_pkg::NORM_W-1:0]      norm_y,
  output logic signed [cvg_pkg::NORM_W-1:0]      norm_z,
  output logic [cvg_pkg::TEX_W-1:0]              tex_u,
  output logic [cvg_pkg::TEX_W-1:0]              tex_v,
  output logic                                   last
);

`include "cylinder_vertex_generator_macros.svh"

  logic [cvg_pkg::RAD_W-1:0] radius;
  logic [cvg_pkg::LEN_W-1:0] cylinder_length;
  cvg_pkg::seg_t             segments;
  logic                      caps_enabled;
  cvg_pkg::seg_t             n;

  logic                      adv;
  logic                      ser_load;

  logic                      in_vld;
  cvg_pkg::seg_t             in_idx;

  logic                      div_vld;
  cvg_pkg::div_item_t        div_item;
  logic                      rot_vld;
  cvg_pkg::rot_item_t        rot_item;

  logic                              p1_vld;
  cvg_pkg::seg_t                     p1_idx;
  logic [cvg_pkg::TEX_W-1:0]         p1_tex;
  logic signed [cvg_pkg::CS_W-1:0]   p1_c;
  logic signed [cvg_pkg::CS_W-1:0]   p1_s;
  logic signed [cvg_pkg::XY_W-1:0]   qc;
  logic signed [cvg_pkg::XY_W-1:0]   qs;

  logic                              p2_vld;
  cvg_pkg::seg_t                     p2_idx;
  logic [cvg_pkg::TEX_W-1:0]         p2_tex;
  logic signed [cvg_pkg::PROD_W-1:0] p2_px;
  logic signed [cvg_pkg::PROD_W-1:0] p2_py;
  logic signed [cvg_pkg::NORM_W-1:0] p2_nx;
  logic signed [cvg_pkg::NORM_W-1:0] p2_ny;

  logic                              p3_vld;
  cvg_pkg::seg_t                     p3_idx;
  logic [cvg_pkg::TEX_W-1:0]         p3_tex;
  logic signed [cvg_pkg::POS_W-1:0]  p3_px;
  logic signed [cvg_pkg::POS_W-1:0]  p3_py;
  logic signed [cvg_pkg::NORM_W-1:0] p3_nx;
  logic signed [cvg_pkg::NORM_W-1:0] p3_ny;

  logic                              ser_valid;
  cvg_pkg::vertex_kind_t             kind;
  logic [cvg_pkg::SLOT_W-1:0]        slot;
  logic signed [cvg_pkg::POS_W-1:0]  ser_px;
  logic signed [cvg_pkg::POS_W-1:0]  ser_py;
  logic signed [cvg_pkg::NORM_W-1:0] ser_nx;
  logic signed [cvg_pkg::NORM_W-1:0] ser_ny;
  logic [cvg_pkg::TEX_W-1:0]         ser_tex;
  logic                              ser_last;
  logic                              out_xfer;
  logic                              is_cap;
  logic                              is_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius          <= cvg_pkg::RAD_W'(256);
      cylinder_length <= cvg_pkg::LEN_W'(256);
      segments        <= cvg_pkg::SEG_W'(32);
      caps_enabled    <= 1'b1;
    end else if (cfg_write) begin
      case (cvg_pkg::reg_index_t'(cfg_index))
        cvg_pkg::REG_RADIUS:   radius          <= cfg_data[cvg_pkg::RAD_W-1:0];
        cvg_pkg::REG_LENGTH:   cylinder_length <= cfg_data[cvg_pkg::LEN_W-1:0];
        cvg_pkg::REG_SEGMENTS: segments        <= cfg_data[cvg_pkg::SEG_W-1:0];
        cvg_pkg::REG_CAPS:     caps_enabled    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (segments < cvg_pkg::SEG_W'(cvg_pkg::N_MIN)) begin
      n = cvg_pkg::SEG_W'(cvg_pkg::N_MIN);
    end else if (segments > cvg_pkg::SEG_W'(cvg_pkg::N_MAX)) begin
      n = cvg_pkg::SEG_W'(cvg_pkg::N_MAX);
    end else begin
      n = segments;
    end
  end

  // The whole pipeline moves as one; it holds only when its last stage is full
  // and the output register cannot take that item.
  assign out_xfer   = vertex_valid && !vertex_stall;
  assign ser_load   = !ser_valid || (out_xfer && ser_last);
  assign adv        = !p3_vld || ser_load;
  assign ring_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else if (adv) begin
      in_vld <= ring_valid;
      p1_vld <= rot_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_idx <= (ring_index > n) ? n : ring_index;
    end
  end

  cvg_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .item_valid   (in_vld),
    .item_idx     (in_idx),
    .n            (n),
    .result_valid (div_vld),
    .result       (div_item)
  );

  cvg_cordic u_cordic (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .item_valid   (div_vld),
    .item         (div_item),
    .result_valid (rot_vld),
    .result       (rot_item)
  );

  always_comb begin
    case (rot_item.quad)
      2'd0: begin
        qc = rot_item.x;
        qs = rot_item.y;
      end
      2'd1: begin
        qc = -rot_item.y;
        qs = rot_item.x;
      end
      2'd2: begin
        qc = -rot_item.x;
        qs = -rot_item.y;
      end
      default: begin
        qc = rot_item.y;
        qs = -rot_item.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_idx <= rot_item.idx;
      p1_tex <= rot_item.tex_u;
      p1_c   <= cvg_pkg::sat_unit(qc);
      p1_s   <= cvg_pkg::sat_unit(qs);

      p2_idx <= p1_idx;
      p2_tex <= p1_tex;
      p2_px  <= $signed({1'b0, radius}) * p1_c;
      p2_py  <= $signed({1'b0, radius}) * p1_s;
      p2_nx  <= cvg_pkg::norm_of(p1_c);
      p2_ny  <= cvg_pkg::norm_of(p1_s);

      p3_idx <= p2_idx;
      p3_tex <= p2_tex;
      p3_px  <= cvg_pkg::pos_of(p2_px);
      p3_py  <= cvg_pkg::pos_of(p2_py);
      p3_nx  <= p2_nx;
      p3_ny  <= p2_ny;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      kind      <= cvg_pkg::KIND_SIDE_BOTTOM;
    end else if (ser_load) begin
      ser_valid <= p3_vld;
      kind      <= cvg_pkg::KIND_SIDE_BOTTOM;
    end else if (out_xfer) begin
      kind      <= cvg_pkg::vertex_kind_t'(kind + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      slot    <= cvg_pkg::SLOT_W'(p3_idx);
      ser_px  <= p3_px;
      ser_py  <= p3_py;
      ser_nx  <= p3_nx;
      ser_ny  <= p3_ny;
      ser_tex <= p3_tex;
    end else if (out_xfer) begin
      slot    <= slot + cvg_pkg::SLOT_W'(n) + cvg_pkg::SLOT_W'(1);
    end
  end

  always_comb begin
    is_cap   = (kind == cvg_pkg::KIND_CAP_BOTTOM) || (kind == cvg_pkg::KIND_CAP_TOP);
    is_top   = (kind == cvg_pkg::KIND_SIDE_TOP) || (kind == cvg_pkg::KIND_CAP_TOP);
    ser_last = caps_enabled ? (kind == cvg_pkg::KIND_CAP_TOP)
                            : (kind == cvg_pkg::KIND_SIDE_TOP);
  end

  assign vertex_valid = ser_valid;
  assign vertex_slot  = slot;
  assign pos_x        = ser_px;
  assign pos_y        = ser_py;
  assign pos_z        = is_top ? cylinder_length : '0;
  assign norm_x       = is_cap ? '0 : ser_nx;
  assign norm_y       = is_cap ? '0 : ser_ny;
  assign norm_z       = is_cap ? (is_top ? cvg_pkg::NORM_ONE : -cvg_pkg::NORM_ONE) : '0;
  assign tex_u        = ser_tex;
  assign tex_v        = (kind == cvg_pkg::KIND_SIDE_TOP) ? cvg_pkg::TEX_ONE : '0;
  assign last         = ser_last;

  `CVG_ASSERT_IMPL(a_stall_only_when_full, clk, rst, ring_stall, p3_vld && ser_valid)
  `CVG_ASSERT_NEXT(a_item_not_cut_short, clk, rst, out_xfer && !last, vertex_valid)
  `CVG_ASSERT_NEXT(a_kind_steps_by_one, clk, rst, out_xfer && !last,
                   kind == cvg_pkg::vertex_kind_t'($past(kind) + 2'd1))

endmodule
